// ----- src/rabm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rabm_pkg
// Shared constants and types for the runs above/below mean counter.
// ---------------------------------------------------------------------------
package rabm_pkg;

  localparam int MAX_RUN = 64;
  localparam int DEPTH   = MAX_RUN + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = 32;
  localparam int SMP_W   = 32;
  localparam int BIDX_W  = 7;

  localparam int KIND_SAMPLE = 0;
  localparam int KIND_READ   = 1;

  // work handed from the tracking stage to the histogram stage
  typedef struct packed {
    logic              rec;
    logic              rd;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  below;
    logic [CNT_W-1:0]  above;
    logic [CNT_W-1:0]  runs;
  } op_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] len_inc(input logic [ADDR_W-1:0] v);
    return (32'(v) >= MAX_RUN) ? ADDR_W'(MAX_RUN) : v + ADDR_W'(1);
  endfunction

endpackage

// ----- src/runs_above_below_mean_counter_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// runs_above_below_mean_counter_unit
// Runs above/below mean counter with saturating run-length histogram.
// ---------------------------------------------------------------------------
// Usage:
//   s_* stream: one word per sample or histogram read. tuser selects kind
//   and marks the first sample of a sequence; tdata carries the sample and
//   the bin index to read.
//   m_* stream: one word per input word with the below, above and run counts
//   after that word, plus the bin count for a read word (zero otherwise).
//   cfg_*: mean level; unenforced user rule: only written while the block is idle.
// Pipeline: 2 register stages (state update and RAM read, then histogram
//   increment and output register); m_tvalid and m_tdata are driven from
//   the output register.
// Throughput: one word per cycle unless the output stalls; the histogram RAM
//   read-modify-write is pipelined with same-address forwarding.
// Reset: counters, run state, mean level and the histogram valid bits are
//   cleared by the synchronous reset; no clearing pass is needed.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready is low.
// ---------------------------------------------------------------------------
module runs_above_below_mean_counter_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,   // mean_level
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,    // kind, first_sample
  input  logic [39:0]  s_tdata,    // sample[31:0], bin_index[38:32], pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata     // below_count, above_count, run_count, bin_value
);
  import rabm_pkg::*;

  logic             adv, accept;
  op_t              op, res_op;
  logic             res_valid;
  logic [CNT_W-1:0] res_bin;

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign accept    = s_tvalid && adv;

  rabm_track u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_mean     (cfg_data),
    .accept       (accept),
    .kind         (s_tuser[0]),
    .first_sample (s_tuser[1]),
    .sample       (s_tdata[31:0]),
    .bin_index    (s_tdata[38:32]),
    .op           (op)
  );

  rabm_hist u_hist (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .accept    (accept),
    .op        (op),
    .res_valid (res_valid),
    .res_op    (res_op),
    .res_bin   (res_bin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {res_bin, res_op.runs, res_op.above, res_op.below};
    end
  end

endmodule

// ----- src/rabm_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rabm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module rabm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rabm_track.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rabm_track
// Mean register, side/run-length state and sequence counters; builds the
// histogram op for each accepted word.
// ---------------------------------------------------------------------------
module rabm_track (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic signed [rabm_pkg::SMP_W-1:0] cfg_mean,
  input  logic                              accept,
  input  logic                              kind,
  input  logic                              first_sample,
  input  logic signed [rabm_pkg::SMP_W-1:0] sample,
  input  logic [rabm_pkg::BIDX_W-1:0]       bin_index,
  output rabm_pkg::op_t                     op
);
  import rabm_pkg::*;

  logic signed [SMP_W-1:0] mean_level;
  logic                    above_flag, above_flag_next;
  logic [ADDR_W-1:0]       up_length, up_length_next;
  logic [ADDR_W-1:0]       down_length, down_length_next;
  logic [CNT_W-1:0]        below_total, below_total_next;
  logic [CNT_W-1:0]        above_total, above_total_next;
  logic [CNT_W-1:0]        runs_total, runs_total_next;
  logic                    lt, gt, is_read, in_range;

  assign lt       = sample < mean_level;
  assign gt       = sample > mean_level;
  assign is_read  = kind == 1'(KIND_READ);
  assign in_range = 32'(bin_index) <= MAX_RUN;

  always_comb begin
    above_flag_next  = above_flag;
    up_length_next   = up_length;
    down_length_next = down_length;
    below_total_next = below_total;
    above_total_next = above_total;
    runs_total_next  = runs_total;
    op.rec      = 1'b0;
    op.rd       = 1'b0;
    op.in_range = 1'b0;
    op.addr     = '0;
    if (is_read) begin
      op.rd       = 1'b1;
      op.in_range = in_range;
      op.addr     = in_range ? ADDR_W'(bin_index) : '0;
    end else if (first_sample) begin
      above_flag_next  = gt;
      up_length_next   = ADDR_W'(gt);
      down_length_next = ADDR_W'(lt);
      below_total_next = CNT_W'(lt);
      above_total_next = CNT_W'(gt);
      runs_total_next  = CNT_W'(lt | gt);
    end else if (lt) begin
      below_total_next = sat_inc(below_total);
      down_length_next = len_inc(down_length);
      if (above_flag) begin
        op.rec          = 1'b1;
        op.addr         = up_length;
        runs_total_next = sat_inc(runs_total);
        above_flag_next = 1'b0;
        up_length_next  = '0;
      end
    end else if (gt) begin
      above_total_next = sat_inc(above_total);
      up_length_next   = len_inc(up_length);
      if (!above_flag) begin
        op.rec           = 1'b1;
        op.addr          = down_length;
        runs_total_next  = sat_inc(runs_total);
        above_flag_next  = 1'b1;
        down_length_next = '0;
      end
    end
    op.below = below_total_next;
    op.above = above_total_next;
    op.runs  = runs_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_level  <= '0;
      above_flag  <= 1'b0;
      up_length   <= '0;
      down_length <= '0;
      below_total <= '0;
      above_total <= '0;
      runs_total  <= '0;
    end else begin
      if (cfg_we) begin
        mean_level <= cfg_mean;
      end
      if (accept) begin
        above_flag  <= above_flag_next;
        up_length   <= up_length_next;
        down_length <= down_length_next;
        below_total <= below_total_next;
        above_total <= above_total_next;
        runs_total  <= runs_total_next;
      end
    end
  end

endmodule

// ----- src/rabm_hist.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rabm_hist
// Run-length histogram: RAM read at accept, increment/write-back or bin
// read one stage later, with forwarding of a same-cycle write.
// ---------------------------------------------------------------------------
module rabm_hist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      accept,
  input  rabm_pkg::op_t             op,
  output logic                      res_valid,
  output rabm_pkg::op_t             res_op,
  output logic [rabm_pkg::CNT_W-1:0] res_bin
);
  import rabm_pkg::*;

  logic             b_valid;
  op_t              b_op;
  logic             b_hit;
  logic [CNT_W-1:0] b_byp;
  logic             b_vbit;
  logic [DEPTH-1:0] vld;
  logic [CNT_W-1:0] rdata, cur, wr_data;
  logic             wr_en, hit_next;

  assign cur      = b_hit ? b_byp : (b_vbit ? rdata : '0);
  assign wr_data  = sat_inc(cur);
  assign wr_en    = adv && b_valid && b_op.rec;
  assign hit_next = wr_en && (b_op.addr == op.addr);

  rabm_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b_op.addr),
    .wdata (wr_data),
    .re    (adv),
    .raddr (op.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      vld     <= '0;
    end else begin
      if (adv) begin
        b_valid <= accept;
      end
      if (wr_en) begin
        vld[b_op.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op   <= op;
      b_hit  <= hit_next;
      b_byp  <= wr_data;
      b_vbit <= vld[op.addr];
    end
  end

  assign res_valid = b_valid;
  assign res_op    = b_op;
  assign res_bin   = (b_op.rd && b_op.in_range) ? cur : '0;

  a_vld_clear: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("histogram valid bits not cleared by reset");
  a_vld_grow: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((vld & $past(vld)) == $past(vld)))
    else $error("histogram valid bit dropped");
  a_wr_nonzero: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_data != '0))
    else $error("histogram write-back of zero");
  a_rd_no_wr: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_op.rd) |-> !wr_en)
    else $error("read word wrote the histogram");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stream test for the runs above/below mean counter.
// Words go in on the s_ stream, each predicted against a local model of the
// counters, run lengths and histogram; every m_ word is checked field by field
// against the oldest prediction. Covers reset state, first-sample cases,
// saturated run lengths, a full bin sweep, several mean levels including both
// extremes, random runs with both sides idling, and a long output stall.
// ---------------------------------------------------------------------------
module tb;
  import rabm_pkg::*;

  localparam logic K_SMP      = 1'(KIND_SAMPLE);
  localparam logic K_RD       = 1'(KIND_READ);
  localparam int   SIDE_BELOW = 0;
  localparam int   SIDE_EQ    = 1;
  localparam int   SIDE_ABOVE = 2;
  localparam int   LONG_HOLD  = 100;

  typedef struct packed {
    logic [31:0] bin_value;
    logic [31:0] run_count;
    logic [31:0] above_count;
    logic [31:0] below_count;
  } counts_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [1:0]   s_tuser = '0;    // kind, first_sample
  logic [39:0]  s_tdata = '0;    // sample[31:0], bin_index[38:32], pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;         // below_count, above_count, run_count, bin_value

  runs_above_below_mean_counter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the block state
  logic [31:0] mean_lvl = '0;
  logic        on_above = 1'b0;
  logic [6:0]  up_len = '0;
  logic [6:0]  down_len = '0;
  logic [31:0] below_cnt = '0;
  logic [31:0] above_cnt = '0;
  logic [31:0] run_cnt = '0;
  logic [31:0] run_hist [0:MAX_RUN] = '{default: '0};

  counts_t expected_counts[$];
  int      errors = 0;
  logic    idle_on = 1'b1;
  int      hold_asks = 0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [6:0] grow(input logic [6:0] len);
    return (len >= 7'(MAX_RUN)) ? 7'(MAX_RUN) : len + 7'd1;
  endfunction

  task automatic log_run(input logic [6:0] len);
    int idx;
    idx = (len > 7'(MAX_RUN)) ? MAX_RUN : int'(len);
    run_hist[idx] = bump(run_hist[idx]);
    run_cnt = bump(run_cnt);
  endtask

  task automatic track_word(input logic kind, input logic first, input logic [31:0] smp,
                            input logic [6:0] bidx);
    counts_t c;
    logic    lt, gt;
    lt = $signed(smp) < $signed(mean_lvl);
    gt = $signed(smp) > $signed(mean_lvl);
    c.bin_value = '0;
    if (kind == K_RD) begin
      if (bidx <= 7'(MAX_RUN)) c.bin_value = run_hist[bidx];
    end else if (first) begin
      below_cnt = lt ? 32'd1 : 32'd0;
      above_cnt = gt ? 32'd1 : 32'd0;
      run_cnt   = (lt || gt) ? 32'd1 : 32'd0;
      down_len  = lt ? 7'd1 : 7'd0;
      up_len    = gt ? 7'd1 : 7'd0;
      on_above  = gt;
    end else if (lt) begin
      below_cnt = bump(below_cnt);
      if (on_above) begin
        log_run(up_len);
        on_above = 1'b0;
        up_len = '0;
      end
      down_len = grow(down_len);
    end else if (gt) begin
      above_cnt = bump(above_cnt);
      if (!on_above) begin
        log_run(down_len);
        on_above = 1'b1;
        down_len = '0;
      end
      up_len = grow(up_len);
    end
    c.below_count = below_cnt;
    c.above_count = above_cnt;
    c.run_count   = run_cnt;
    expected_counts.push_back(c);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    counts_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_counts.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        want = expected_counts.pop_front();
        check_field("below_count", want.below_count, got.below_count);
        check_field("above_count", want.above_count, got.above_count);
        check_field("run_count", want.run_count, got.run_count);
        check_field("bin_value", want.bin_value, got.bin_value);
      end
    end
  end

  // output side: random stall bursts, plus a long hold on request
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic kind, input logic first, input logic [31:0] smp,
                           input logic [6:0] bidx);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {first, kind};
    s_tdata  <= {1'b0, bidx, smp};
    do @(posedge clk); while (!s_tready);
    track_word(kind, first, smp, bidx);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mean(input logic [31:0] lvl);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= lvl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mean_lvl = lvl;
  endtask

  // sample strictly below, equal to or strictly above the current mean; the mean itself where no such value exists
  function automatic logic [31:0] value_on(input int side);
    longint m, span, off;
    m = longint'($signed(mean_lvl));
    if (side == SIDE_EQ) return mean_lvl;
    span = (side == SIDE_BELOW) ? m + 64'sd2147483648 : 64'sd2147483647 - m;
    if (span == 0) return mean_lvl;
    case ($urandom_range(0, 7))
      0:       off = span - 1;
      1, 2, 3: off = longint'($urandom_range(0, 3)) % span;
      default: off = longint'($urandom) % span;
    endcase
    return (side == SIDE_BELOW) ? 32'(m - 1 - off) : 32'(m + 1 + off);
  endfunction

  task automatic random_words(input int n_words);
    int         side, run_left, pick;
    logic [6:0] bidx;
    side = SIDE_BELOW;
    run_left = 0;
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        bidx = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(MAX_RUN + 1, 127))
                                          : 7'($urandom_range(0, MAX_RUN));
        send_word(K_RD, 1'($urandom), $urandom, bidx);
      end else if (pick < 16) begin
        send_word(K_SMP, 1'b1, value_on($urandom_range(0, 2)), 7'($urandom));
        run_left = 0;
      end else if (pick < 24) begin
        send_word(K_SMP, 1'b0, value_on(SIDE_EQ), 7'($urandom));
      end else begin
        if (run_left == 0) begin
          side = (side == SIDE_BELOW) ? SIDE_ABOVE : SIDE_BELOW;
          run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24)
                                                 : $urandom_range(1, 5);
        end
        run_left--;
        send_word(K_SMP, 1'b0, value_on(side), 7'($urandom));
      end
    end
  endtask

  task automatic test_reset_state();
    send_word(K_RD, 1'b0, 32'h0, 7'd0);
    send_word(K_RD, 1'b1, 32'hDEAD_BEEF, 7'(MAX_RUN));
    // no first sample yet: continues from the reset state
    send_word(K_SMP, 1'b0, 32'hFFFF_FFFB, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0000_0007, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0000_0000, 7'd0);
    send_word(K_RD, 1'b0, 32'h0, 7'd1);
  endtask

  task automatic test_first_sample_cases();
    set_mean(32'h0001_0000);
    // first sample on the mean, then above: zero-length run lands in bin 0
    send_word(K_SMP, 1'b1, 32'h0001_0000, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0001_0001, 7'd0);
    send_word(K_SMP, 1'b1, 32'h8000_0000, 7'h7F);
    send_word(K_SMP, 1'b0, 32'h7FFF_FFFF, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0001_0000, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0000_FFFF, 7'd0);
    send_word(K_SMP, 1'b1, 32'h0002_0000, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0003_0000, 7'd0);
    send_word(K_SMP, 1'b0, 32'hFFFF_0000, 7'd0);
    send_word(K_SMP, 1'b0, 32'h0001_8000, 7'd0);
    send_word(K_RD, 1'b0, 32'h0, 7'd0);
    send_word(K_RD, 1'b0, 32'h0, 7'd1);
    send_word(K_RD, 1'b0, 32'h0, 7'd2);
    send_word(K_RD, 1'b1, 32'hFFFF_FFFF, 7'(MAX_RUN + 1));
    send_word(K_RD, 1'b0, 32'h0, 7'h7F);
  endtask

  task automatic test_long_runs();
    int run_lens [5] = '{63, 64, 66, 1, 2};
    int side;
    set_mean($urandom);
    side = SIDE_BELOW;
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < run_lens[k]; j++)
        send_word(K_SMP, 1'(k == 0 && j == 0), value_on(side), 7'($urandom));
      side = (side == SIDE_BELOW) ? SIDE_ABOVE : SIDE_BELOW;
    end
    send_word(K_SMP, 1'b0, value_on(side), 7'd0);
    for (int b = 0; b <= MAX_RUN + 1; b++)
      send_word(K_RD, 1'($urandom), $urandom, 7'(b));
    send_word(K_RD, 1'b0, $urandom, 7'h7F);
  endtask

  task automatic random_phase(input logic [31:0] lvl, input int n_words);
    set_mean(lvl);
    random_words(n_words);
  endtask

  task automatic test_backpressure();
    set_mean(32'hFFFE_8000);
    hold_asks <= hold_asks + 1;
    random_words(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_first_sample_cases();
    test_long_runs();
    random_phase(32'h8000_0000, 25);
    random_phase(32'h7FFF_FFFF, 25);
    random_phase(32'h0000_0000, 25);
    random_phase($urandom, 25);
    test_backpressure();
    idle_on <= 1'b0;
    random_phase(32'h0001_8000, 25);
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
